// ----- hw/rtl/mbrp_pkg.sv -----
// Shared types, constants and helpers for the MBR partition table parser.
// Used by mbrp_alu, mbrp_eval and mbr_partition_table_parser; no dependencies.
package mbrp_pkg;

  localparam int unsigned DefPrimaryEntries = 4;

  localparam int unsigned DiskW    = 48;
  localparam int unsigned SecBytesW = 16;
  localparam int unsigned LbaW     = 32;
  localparam int unsigned EndW     = 33;
  localparam int unsigned AluW     = 49;
  localparam int unsigned PosW     = 9;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PosW-1:0] TableBase = 9'd446;
  localparam logic [PosW-1:0] SigPos    = 9'd510;
  localparam logic [PosW-1:0] LastPos   = 9'd511;
  localparam int unsigned     EntryLen  = 16;

  localparam logic [7:0] SigLow      = 8'h55;
  localparam logic [7:0] SigHigh     = 8'haa;
  localparam logic [7:0] BootNone    = 8'h00;
  localparam logic [7:0] BootActive  = 8'h80;
  localparam logic [7:0] TypeExtChs  = 8'h05;
  localparam logic [7:0] TypeExtLba  = 8'h0f;
  localparam logic [7:0] TypeExtLnx  = 8'h85;

  localparam logic [SecBytesW-1:0] MinSectorBytes = 16'd512;
  localparam logic [SecBytesW-1:0] ResetSectorBytes = 16'd512;

  // Bytes fetched per entry: flag, type, four start bytes, four count bytes.
  localparam logic [3:0] ReadCount = 4'd10;

  localparam logic [CfgIdxW-1:0] CfgDiskSectors = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSectorBytes = 2'd1;

  localparam logic KindPart    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusBadSig = 2'd1,
    StatusSmall  = 2'd2
  } status_e;

  typedef struct packed {
    logic              start;
    status_e           status;
  } eval_start_t;

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] res;
    logic            borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic            rec_kind;
    logic [2:0]      part_number;
    logic [7:0]      part_type;
    logic [LbaW-1:0] first_sector;
    logic [LbaW-1:0] sector_total;
    status_e         status;
    logic [2:0]      found_count;
    logic            last_of_run;
  } out_rec_t;

  // Entry byte offset of the n-th fetch in an entry.
  function automatic logic [3:0] rd_offset(input logic [3:0] n);
    logic [3:0] off;
    case (n)
      4'd0:    off = 4'd0;
      4'd1:    off = 4'd4;
      default: off = n + 4'd6;
    endcase
    return off;
  endfunction

  function automatic logic is_extended(input logic [7:0] t);
    return (t == TypeExtChs) || (t == TypeExtLba) || (t == TypeExtLnx);
  endfunction

endpackage

// ----- hw/rtl/mbr_partition_table_parser.sv -----
// Top level of the MBR partition table parser: byte intake, config registers,
// entry store and evaluator. Depends on mbrp_pkg, mbrp_ram, mbrp_eval.
//
// Sector 0 streams in one byte per beat on the input channel, positions 0 to
// 511, and the block takes one beat per cycle while it is collecting. Bytes
// 446 onward of the first PRIMARY_ENTRIES table entries go into a small entry
// RAM, and byte 510 is held for the signature check. The beat carrying byte
// 511 triggers evaluation, and input ready stays low until the summary record
// has been loaded into the output register. A too-small sector size or a bad
// signature loads the summary at once. Otherwise each entry is fetched from
// the RAM (one RAM read port, registered read), then judged with one shared
// 49-bit adder: one add for the end sector, one subtract for the disk bound,
// two subtracts per table slot for the overlap test. An accepted entry also
// waits while the output channel stalls. Each accepted entry gives one
// partition record; one summary record with last_of_run set closes the run.
// Configuration writes are always taken; write disk_sectors and
// disk_sector_bytes only while no sector is in progress.
module mbr_partition_table_parser #(
  parameter int unsigned PRIMARY_ENTRIES = mbrp_pkg::DefPrimaryEntries
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbrp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mbrp_pkg::DiskW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            rec_kind_o,
  output logic [2:0]                      part_number_o,
  output logic [7:0]                      part_type_o,
  output logic [mbrp_pkg::LbaW-1:0]       first_sector_o,
  output logic [mbrp_pkg::LbaW-1:0]       sector_total_o,
  output logic [1:0]                      status_o,
  output logic [2:0]                      found_count_o,
  output logic                            last_of_run_o
);
  import mbrp_pkg::*;

  localparam int unsigned IdxW  = (PRIMARY_ENTRIES > 1) ? $clog2(PRIMARY_ENTRIES) : 1;
  localparam int unsigned AddrW = IdxW + 4;
  localparam int unsigned RamDepth = 2 ** AddrW;
  // One past the last stored table byte.
  localparam logic [PosW:0] TableEnd = (PosW + 1)'(TableBase) +
                                       (PosW + 1)'(PRIMARY_ENTRIES * EntryLen);

  logic [DiskW-1:0]     disk_sectors_q;
  logic [SecBytesW-1:0] sector_bytes_q;
  logic [PosW-1:0]      pos_q;
  logic [7:0]           sig_low_q;

  logic                 in_beat;
  logic                 table_byte;
  logic [PosW-1:0]      table_off;
  logic [AddrW-1:0]     rd_addr;
  logic [7:0]           rd_data;
  logic                 eval_idle;
  eval_start_t          eval_start;
  out_rec_t             out_rec;

  assign cfg_ready_o = 1'b1;

  // Config registers: drop writes to indexes beyond the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_sectors_q <= '0;
      sector_bytes_q <= ResetSectorBytes;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDiskSectors: disk_sectors_q <= cfg_data_i;
        CfgSectorBytes: sector_bytes_q <= cfg_data_i[SecBytesW-1:0];
        default:        disk_sectors_q <= disk_sectors_q;
      endcase
    end
  end

  assign in_ready_o = eval_idle;
  assign in_beat    = in_valid_i & in_ready_o;

  // Advance the byte position on every beat; it wraps from 511 back to 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sig_low_q <= '0;
    end else if (in_beat) begin
      pos_q <= pos_q + 1'b1;
      if (pos_q == SigPos) begin
        sig_low_q <= data_byte_i;
      end
    end
  end

  // Only bytes of entries that get judged are kept.
  assign table_off  = pos_q - TableBase;
  assign table_byte = in_beat && (pos_q >= TableBase) && ({1'b0, pos_q} < TableEnd);

  mbrp_ram #(
    .Width (8),
    .Depth (RamDepth),
    .AddrW (AddrW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (table_byte),
    .waddr_i (table_off[AddrW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // The last byte starts evaluation; the sector size test takes priority
  // over the signature test.
  always_comb begin
    eval_start.start = in_beat && (pos_q == LastPos);
    if (sector_bytes_q < MinSectorBytes) begin
      eval_start.status = StatusSmall;
    end else if (sig_low_q != SigLow || data_byte_i != SigHigh) begin
      eval_start.status = StatusBadSig;
    end else begin
      eval_start.status = StatusOk;
    end
  end

  mbrp_eval #(
    .PRIMARY_ENTRIES (PRIMARY_ENTRIES),
    .IdxW            (IdxW),
    .AddrW           (AddrW)
  ) u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (eval_start),
    .disk_sectors_i (disk_sectors_q),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .idle_o         (eval_idle),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_rec_o      (out_rec)
  );

  assign rec_kind_o     = out_rec.rec_kind;
  assign part_number_o  = out_rec.part_number;
  assign part_type_o    = out_rec.part_type;
  assign first_sector_o = out_rec.first_sector;
  assign sector_total_o = out_rec.sector_total;
  assign status_o       = out_rec.status;
  assign found_count_o  = out_rec.found_count;
  assign last_of_run_o  = out_rec.last_of_run;

endmodule

// ----- hw/rtl/mbrp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mbrp_alu.sv -----
// Shared 49-bit add/subtract unit with borrow flag for the entry checks.
// Depends on mbrp_pkg.
module mbrp_alu (
  input  mbrp_pkg::alu_req_t req_i,
  output mbrp_pkg::alu_rsp_t rsp_o
);
  import mbrp_pkg::*;

  logic [AluW:0] sum;

  assign sum = {1'b0, req_i.a} + {1'b0, req_i.b ^ {AluW{req_i.sub}}} + (AluW + 1)'(req_i.sub);

  assign rsp_o.res    = sum[AluW-1:0];
  assign rsp_o.borrow = req_i.sub & ~sum[AluW];

endmodule

// ----- hw/rtl/mbrp_eval.sv -----
// Entry evaluation sequencer: fetches entry bytes, runs the checks through
// the shared adder and holds the result register. Depends on mbrp_pkg, mbrp_alu.
module mbrp_eval #(
  parameter int unsigned PRIMARY_ENTRIES = mbrp_pkg::DefPrimaryEntries,
  parameter int unsigned IdxW = (PRIMARY_ENTRIES > 1) ? $clog2(PRIMARY_ENTRIES) : 1,
  parameter int unsigned AddrW = IdxW + 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbrp_pkg::eval_start_t         start_i,
  input  logic [mbrp_pkg::DiskW-1:0]    disk_sectors_i,
  output logic [AddrW-1:0]              rd_addr_o,
  input  logic [7:0]                    rd_data_i,
  output logic                          idle_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbrp_pkg::out_rec_t            out_rec_o
);
  import mbrp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_ADD, S_FIT, S_OVL_A, S_OVL_B, S_EMIT, S_NEXT, S_SUM
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PRIMARY_ENTRIES - 1);

  state_e               state_q;
  logic [IdxW-1:0]      e_q;
  logic [IdxW-1:0]      j_q;
  logic [3:0]           rd_cnt_q;
  logic [3:0]           cap_idx_q;
  logic                 cap_vld_q;
  logic                 hit_q;
  logic [2:0]           found_q;
  status_e              sum_status_q;
  logic [PRIMARY_ENTRIES-1:0] acc_valid_q;
  logic                 out_valid_q;
  out_rec_t             out_q;

  logic [7:0]           flag_q;
  logic [7:0]           type_q;
  logic [LbaW-1:0]      start_q;
  logic [LbaW-1:0]      count_q;
  logic [EndW-1:0]      end_q;
  logic                 lt_q;
  logic [LbaW-1:0]      acc_start_q [PRIMARY_ENTRIES];
  logic [EndW-1:0]      acc_end_q   [PRIMARY_ENTRIES];

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     basic_ok;
  logic     hit_now;

  mbrp_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign basic_ok = (type_q != 8'd0) && (count_q != '0) &&
                    ((flag_q == BootNone) || (flag_q == BootActive)) &&
                    !is_extended(type_q) && (start_q != '0);

  assign hit_now = acc_valid_q[j_q] && lt_q && alu_rsp.borrow;

  always_comb begin
    alu_req = '0;
    case (state_q)
      S_ADD: begin
        alu_req.a   = AluW'(start_q);
        alu_req.b   = AluW'(count_q);
        alu_req.sub = 1'b0;
      end
      S_FIT: begin
        alu_req.a   = AluW'(disk_sectors_i);
        alu_req.b   = AluW'(end_q);
        alu_req.sub = 1'b1;
      end
      S_OVL_A: begin
        alu_req.a   = AluW'(start_q);
        alu_req.b   = AluW'(acc_end_q[j_q]);
        alu_req.sub = 1'b1;
      end
      S_OVL_B: begin
        alu_req.a   = AluW'(acc_start_q[j_q]);
        alu_req.b   = AluW'(end_q);
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  assign rd_addr_o = {e_q, rd_offset(rd_cnt_q)};

  // Sequencer state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      e_q          <= '0;
      j_q          <= '0;
      rd_cnt_q     <= '0;
      cap_idx_q    <= '0;
      cap_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      found_q      <= '0;
      sum_status_q <= StatusOk;
      acc_valid_q  <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (start_i.start) begin
            acc_valid_q  <= '0;
            found_q      <= '0;
            e_q          <= '0;
            rd_cnt_q     <= '0;
            cap_vld_q    <= 1'b0;
            sum_status_q <= start_i.status;
            state_q      <= (start_i.status != StatusOk) ? S_SUM : S_READ;
          end
        end
        S_READ: begin
          if (rd_cnt_q != ReadCount) begin
            cap_vld_q <= 1'b1;
            cap_idx_q <= rd_cnt_q;
            rd_cnt_q  <= rd_cnt_q + 4'd1;
          end else begin
            cap_vld_q <= 1'b0;
            state_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_q <= basic_ok ? S_ADD : S_NEXT;
        end
        S_ADD: begin
          state_q <= S_FIT;
        end
        S_FIT: begin
          j_q     <= '0;
          hit_q   <= 1'b0;
          state_q <= alu_rsp.borrow ? S_NEXT : S_OVL_A;
        end
        S_OVL_A: begin
          state_q <= S_OVL_B;
        end
        S_OVL_B: begin
          hit_q <= hit_q | hit_now;
          if (j_q == LastIdx) begin
            state_q <= (hit_q | hit_now) ? S_NEXT : S_EMIT;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_OVL_A;
          end
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q       <= 1'b1;
            out_q.rec_kind    <= KindPart;
            out_q.part_number <= 3'(e_q) + 3'd1;
            out_q.part_type   <= type_q;
            out_q.first_sector <= start_q;
            out_q.sector_total <= count_q;
            out_q.status      <= StatusOk;
            out_q.found_count <= '0;
            out_q.last_of_run <= 1'b0;
            acc_valid_q[e_q]  <= 1'b1;
            found_q           <= found_q + 3'd1;
            state_q           <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (e_q == LastIdx) begin
            state_q <= S_SUM;
          end else begin
            e_q       <= e_q + 1'b1;
            rd_cnt_q  <= '0;
            cap_vld_q <= 1'b0;
            state_q   <= S_READ;
          end
        end
        S_SUM: begin
          if (!out_valid_q) begin
            out_valid_q        <= 1'b1;
            out_q.rec_kind     <= KindSummary;
            out_q.part_number  <= '0;
            out_q.part_type    <= '0;
            out_q.first_sector <= '0;
            out_q.sector_total <= '0;
            out_q.status       <= sum_status_q;
            out_q.found_count  <= found_q;
            out_q.last_of_run  <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Entry fields, end sector and the accepted-range table.
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ && cap_vld_q) begin
      case (cap_idx_q)
        4'd0:    flag_q         <= rd_data_i;
        4'd1:    type_q         <= rd_data_i;
        4'd2:    start_q[7:0]   <= rd_data_i;
        4'd3:    start_q[15:8]  <= rd_data_i;
        4'd4:    start_q[23:16] <= rd_data_i;
        4'd5:    start_q[31:24] <= rd_data_i;
        4'd6:    count_q[7:0]   <= rd_data_i;
        4'd7:    count_q[15:8]  <= rd_data_i;
        4'd8:    count_q[23:16] <= rd_data_i;
        4'd9:    count_q[31:24] <= rd_data_i;
        default: flag_q         <= flag_q;
      endcase
    end
    if (state_q == S_ADD) begin
      end_q <= alu_rsp.res[EndW-1:0];
    end
    if (state_q == S_OVL_A) begin
      lt_q <= alu_rsp.borrow;
    end
    if (state_q == S_EMIT && !out_valid_q) begin
      acc_start_q[e_q] <= start_q;
      acc_end_q[e_q]   <= end_q;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;

  a_start_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i.start |-> state_q == S_IDLE)
    else $error("evaluation start while busy");

  a_found_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(acc_valid_q) == found_q)
    else $error("accepted count out of step with valid bits");

  a_summary_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rec_kind == KindSummary |-> out_q.found_count <= PRIMARY_ENTRIES)
    else $error("summary count exceeds entry count");

  a_part_record_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rec_kind == KindPart
      |-> out_q.part_type != 8'd0 && out_q.sector_total != '0 && out_q.first_sector != '0)
    else $error("partition record with empty fields");

endmodule
